[rtl/tfd_pkg.sv]
// Shared constants and request/response types for the telecine frame decimator.
package tfd_pkg;

   localparam int RING_SLOTS       = 15;
   localparam int SAMPLE_STEP      = 16;
   localparam int MAX_FRAME_PIXELS = 2097152;
   localparam int GROUP_LEN        = 5;

   localparam int STORE_DEPTH = (MAX_FRAME_PIXELS + SAMPLE_STEP - 1) / SAMPLE_STEP;
   localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int POS_W       = $clog2(MAX_FRAME_PIXELS + 1);
   localparam int PHASE_W     = (SAMPLE_STEP > 1) ? $clog2(SAMPLE_STEP) : 1;
   localparam int SLOT_W      = $clog2(RING_SLOTS);
   localparam int COUNT_W     = $clog2(GROUP_LEN + 1);
   localparam int GIDX_W      = $clog2(GROUP_LEN);
   localparam int PIXEL_W     = 8;
   localparam int SUM_W       = 32;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel_value;
      logic               end_of_frame;
   } req_type;

   typedef struct packed {
      logic [SLOT_W-1:0] out_slot;
      logic              give_frame;
      logic              warming_up;
   } rsp_type;

endpackage

[rtl/telecine_frame_decimator_top.sv]
// Frame decimator top level: sampled frame difference sums and 5-to-4 drop verdicts.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  tfd_pkg::req_type, one luma byte
//   rsp      out        rsp_valid/rsp_stall  tfd_pkg::rsp_type, one verdict per frame
//
// One request per cycle unless stalled; verdicts pass through s1, s2 and rsp registers.
// Stages: sample store read, sum accumulate, verdict decision, response register.
// The sample store read port is the one per-cycle resource; a same-address write
// from the previous request is forwarded around it.
// Synchronous reset clears control state; the sample store itself is not cleared.
// A stalled response holds the decision stage; non-final bytes flow until an end-of-frame waits.
module telecine_frame_decimator_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  tfd_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output tfd_pkg::rsp_type rsp_data
);
   import tfd_pkg::*;

   logic [PIXEL_W-1:0] sample_mem [STORE_DEPTH];

   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [ADDR_W-1:0]  idx_ff, idx_in;

   logic               s1_valid_ff, s1_valid_in;
   logic [PIXEL_W-1:0] s1_pixel_ff;
   logic               s1_eof_ff;
   logic               s1_sample_ff;
   logic [ADDR_W-1:0]  s1_idx_ff;
   logic               s1_bypass_ff;
   logic [PIXEL_W-1:0] s1_fwd_ff;
   logic [PIXEL_W-1:0] rd_data_ff;

   logic [SUM_W-1:0]   acc_ff, acc_in;

   logic               s2_valid_ff, s2_valid_in;
   logic [SUM_W-1:0]   s2_total_ff;

   logic [SUM_W-1:0]   sums_ff [GROUP_LEN];
   logic [COUNT_W-1:0] seen_ff, seen_in;
   logic [COUNT_W-1:0] gphase_ff, gphase_in;
   logic [SLOT_W-1:0]  wslot_ff, wslot_in;
   logic [SLOT_W-1:0]  rslot_ff, rslot_in;
   logic [RING_SLOTS-1:0] keep_ff, keep_in;

   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic               req_fire, do_sample, s1_fire, s1_write;
   logic               s2_free, s2_move, rsp_free;
   logic [PIXEL_W-1:0] old_pixel, abs_diff;
   logic [SUM_W-1:0]   total;
   logic [SUM_W-1:0]   new_sums [GROUP_LEN];
   logic [GROUP_LEN-1:0] least;
   logic [GIDX_W-1:0]  drop_idx;
   logic [SLOT_W:0]    drop_sum;
   logic [SLOT_W-1:0]  drop_slot;
   logic               warm, do_drop;
   logic [SLOT_W-1:0]  wslot_next, rslot_next;

   // handshake
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign s2_move   = s2_valid_ff && rsp_free;
   assign s2_free   = !s2_valid_ff || rsp_free;
   assign s1_fire   = s1_valid_ff && (!s1_eof_ff || s2_free);
   assign s1_write  = s1_fire && s1_sample_ff;
   assign req_stall = s1_valid_ff && !s1_fire;
   assign req_fire  = req_valid && !req_stall;

   // position tracking
   assign do_sample = (pos_ff < POS_W'(MAX_FRAME_PIXELS)) && (phase_ff == '0);

   always_comb begin
      pos_in   = pos_ff;
      phase_in = phase_ff;
      idx_in   = idx_ff;
      if (req_fire) begin
         if (req_data.end_of_frame) begin
            pos_in   = '0;
            phase_in = '0;
            idx_in   = '0;
         end else if (pos_ff < POS_W'(MAX_FRAME_PIXELS)) begin
            pos_in = pos_ff + POS_W'(1);
            if (phase_ff == PHASE_W'(SAMPLE_STEP - 1)) begin
               phase_in = '0;
               idx_in   = idx_ff + ADDR_W'(1);
            end else begin
               phase_in = phase_ff + PHASE_W'(1);
            end
         end
      end
   end

   // sample store
   always_ff @(posedge clock) begin
      if (s1_write) begin
         sample_mem[s1_idx_ff] <= s1_pixel_ff;
      end
      if (req_fire) begin
         rd_data_ff <= sample_mem[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_pixel_ff  <= req_data.pixel_value;
         s1_eof_ff    <= req_data.end_of_frame;
         s1_sample_ff <= do_sample;
         s1_idx_ff    <= idx_ff;
         s1_bypass_ff <= s1_write && (s1_idx_ff == idx_ff);
         s1_fwd_ff    <= s1_pixel_ff;
      end
   end

   assign s1_valid_in = req_fire || (s1_valid_ff && !s1_fire);

   // accumulate
   assign old_pixel = s1_bypass_ff ? s1_fwd_ff : rd_data_ff;
   assign abs_diff  = (s1_pixel_ff > old_pixel) ? (s1_pixel_ff - old_pixel)
                                                : (old_pixel - s1_pixel_ff);
   assign total     = s1_sample_ff ? (acc_ff + SUM_W'(abs_diff)) : acc_ff;

   always_comb begin
      acc_in = acc_ff;
      if (s1_fire) begin
         acc_in = s1_eof_ff ? '0 : total;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire && s1_eof_ff) begin
         s2_total_ff <= total;
      end
   end

   assign s2_valid_in = (s1_fire && s1_eof_ff) || (s2_valid_ff && !s2_move);

   // verdict decision
   always_comb begin
      for (int k = 0; k < GROUP_LEN - 1; k++) begin
         new_sums[k] = sums_ff[k+1];
      end
      new_sums[GROUP_LEN-1] = s2_total_ff;
   end

   always_comb begin
      for (int k = 0; k < GROUP_LEN; k++) begin
         least[k] = 1'b1;
         for (int j = 0; j < GROUP_LEN; j++) begin
            if (j != k && !(new_sums[k] < new_sums[j])) begin
               least[k] = 1'b0;
            end
         end
      end
   end

   always_comb begin
      drop_idx = '0;
      for (int k = GROUP_LEN - 1; k >= 0; k--) begin
         if (least[k]) begin
            drop_idx = GIDX_W'(k);
         end
      end
   end

   assign drop_sum   = {1'b0, rslot_ff} + (SLOT_W+1)'(drop_idx);
   assign drop_slot  = (drop_sum >= (SLOT_W+1)'(RING_SLOTS))
                       ? SLOT_W'(drop_sum - (SLOT_W+1)'(RING_SLOTS))
                       : drop_sum[SLOT_W-1:0];
   assign wslot_next = (wslot_ff == SLOT_W'(RING_SLOTS - 1)) ? '0 : wslot_ff + SLOT_W'(1);
   assign rslot_next = (rslot_ff == SLOT_W'(RING_SLOTS - 1)) ? '0 : rslot_ff + SLOT_W'(1);
   assign warm       = seen_ff < COUNT_W'(GROUP_LEN);
   assign do_drop    = !warm && (gphase_ff == '0);

   always_comb begin
      seen_in      = seen_ff;
      gphase_in    = gphase_ff;
      wslot_in     = wslot_ff;
      rslot_in     = rslot_ff;
      keep_in      = keep_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (s2_move) begin
         keep_in[wslot_ff] = 1'b1;
         wslot_in  = wslot_next;
         gphase_in = (gphase_ff == COUNT_W'(GROUP_LEN - 1)) ? '0 : gphase_ff + COUNT_W'(1);
         rsp_valid_in = 1'b1;
         if (warm) begin
            seen_in = seen_ff + COUNT_W'(1);
            rsp_data_in.out_slot   = '0;
            rsp_data_in.give_frame = 1'b0;
            rsp_data_in.warming_up = 1'b1;
         end else begin
            if (do_drop) begin
               keep_in[drop_slot] = 1'b0;
            end
            rsp_data_in.out_slot   = rslot_ff;
            rsp_data_in.give_frame = keep_in[rslot_ff];
            rsp_data_in.warming_up = 1'b0;
            rslot_in = rslot_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s2_move) begin
         for (int k = 0; k < GROUP_LEN; k++) begin
            sums_ff[k] <= new_sums[k];
         end
      end
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         phase_ff     <= '0;
         idx_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         acc_ff       <= '0;
         s2_valid_ff  <= 1'b0;
         seen_ff      <= '0;
         gphase_ff    <= '0;
         wslot_ff     <= '0;
         rslot_ff     <= '0;
         keep_ff      <= '1;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         phase_ff     <= phase_in;
         idx_ff       <= idx_in;
         s1_valid_ff  <= s1_valid_in;
         acc_ff       <= acc_in;
         s2_valid_ff  <= s2_valid_in;
         seen_ff      <= seen_in;
         gphase_ff    <= gphase_in;
         wslot_ff     <= wslot_in;
         rslot_ff     <= rslot_in;
         keep_ff      <= keep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[dv/tb.sv]
`timescale 1ns / 100ps
// Testbench for the telecine frame decimator: queued luma stream, self-predicted verdicts.
module tb;
   import tfd_pkg::*;

   localparam int FIRST_LEN    = 600;
   localparam int SHADOW_LEN   = 1024;
   localparam int RANDOM_ITEMS = 1300;
   localparam int RANDOM_FRAMES = 25;
   localparam int HOLD_AT      = 30;
   localparam int HOLD_LEN     = 400;
   localparam int QUIET_LIMIT  = 5000;
   localparam int DRAIN_CYCLES = 20;

   localparam logic [7:0] DIRECTED_LUMA [20] = '{
      8'd0,   8'd0,   8'd0,   8'd0,   8'd255,
      8'd0,   8'd255, 8'd255, 8'd0,   8'd255,
      8'd254, 8'd254, 8'd0,   8'd128, 8'd7,
      8'd200, 8'd100, 8'd50,  8'd60,  8'd61
   };

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   req_type pending_reqs [$];
   rsp_type expected_verdicts [$];
   rsp_type want;

   logic [7:0]  luma_shadow [SHADOW_LEN];
   int unsigned gen_pos = 0;

   bit [7:0]    prior_store [STORE_DEPTH];
   bit [31:0]   frame_sad = 0;
   bit [31:0]   pair_window [GROUP_LEN] = '{default: 0};
   int unsigned pixel_pos = 0;
   int unsigned frames_seen = 0;
   int unsigned group_phase = 0;
   int unsigned write_slot = 0;
   int unsigned read_slot = 0;
   bit          keep_slot [RING_SLOTS] = '{default: 1'b1};

   int unsigned requests_taken = 0;
   int unsigned verdicts_seen = 0;
   int unsigned mismatches = 0;
   int unsigned hold_left = 0;
   bit          hold_done = 1'b0;

   telecine_frame_decimator_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #6 clock = ~clock;

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   end

   function automatic int unsigned ring_next(input int unsigned s);
      return (s + 1 >= RING_SLOTS) ? 0 : s + 1;
   endfunction

   function automatic int unsigned lowest_sum_index();
      bit least;
      for (int k = 0; k < GROUP_LEN; k++) begin
         least = 1'b1;
         for (int j = 0; j < GROUP_LEN; j++) begin
            if (j != k && !(pair_window[k] < pair_window[j])) least = 1'b0;
         end
         if (least) return k;
      end
      return 0;
   endfunction

   task automatic advance_decimator(input req_type r);
      bit [7:0]    old;
      int unsigned idx;
      int unsigned s;
      rsp_type     v;
      if (pixel_pos < MAX_FRAME_PIXELS) begin
         if (pixel_pos % SAMPLE_STEP == 0) begin
            idx = pixel_pos / SAMPLE_STEP;
            old = prior_store[idx];
            frame_sad += (r.pixel_value > old) ? 32'(r.pixel_value - old)
                                               : 32'(old - r.pixel_value);
            prior_store[idx] = r.pixel_value;
         end
         pixel_pos++;
      end
      if (!r.end_of_frame) return;

      for (int k = 0; k + 1 < GROUP_LEN; k++) pair_window[k] = pair_window[k + 1];
      pair_window[GROUP_LEN - 1] = frame_sad;
      frame_sad = 0;
      pixel_pos = 0;
      keep_slot[write_slot] = 1'b1;
      write_slot = ring_next(write_slot);

      if (frames_seen < GROUP_LEN) begin
         frames_seen++;
         group_phase = (group_phase + 1) % GROUP_LEN;
         v.out_slot = '0;
         v.give_frame = 1'b0;
         v.warming_up = 1'b1;
         expected_verdicts.push_back(v);
         return;
      end

      if (group_phase == 0) begin
         s = read_slot;
         for (int k = lowest_sum_index(); k > 0; k--) s = ring_next(s);
         keep_slot[s] = 1'b0;
      end
      group_phase = (group_phase + 1) % GROUP_LEN;
      v.out_slot = SLOT_W'(read_slot);
      v.give_frame = keep_slot[read_slot];
      v.warming_up = 1'b0;
      expected_verdicts.push_back(v);
      read_slot = ring_next(read_slot);
   endtask

   task automatic queue_byte(input logic [7:0] value, input logic last);
      req_type item;
      item.pixel_value = value;
      item.end_of_frame = last;
      pending_reqs.push_back(item);
      if (gen_pos < SHADOW_LEN) luma_shadow[gen_pos] = value;
      gen_pos = last ? 0 : gen_pos + 1;
   endtask

   initial begin : stimulus
      int unsigned len;
      int unsigned mode;
      int unsigned pick;
      int unsigned random_items;
      int unsigned random_frames;
      logic [7:0]  value;
      random_items = 0;
      random_frames = 0;
      for (int i = 0; i < FIRST_LEN; i++)
         queue_byte((i == 0) ? 8'd0 : 8'($urandom_range(255)), i == FIRST_LEN - 1);
      foreach (DIRECTED_LUMA[i]) queue_byte(DIRECTED_LUMA[i], 1'b1);
      while (random_items < RANDOM_ITEMS || random_frames < RANDOM_FRAMES) begin
         pick = $urandom_range(99);
         if (pick < 60) len = $urandom_range(24, 1);
         else if (pick < 92) len = $urandom_range(120, 25);
         else len = $urandom_range(FIRST_LEN, 121);
         mode = $urandom_range(2);
         for (int p = 0; p < len; p++) begin
            case (mode)
               0: value = 8'($urandom_range(255));
               1: value = luma_shadow[p];
               default: value = ($urandom_range(7) == 0) ? 8'($urandom_range(255))
                                                         : luma_shadow[p];
            endcase
            queue_byte(value, p == len - 1);
         end
         random_items += len;
         random_frames++;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data <= '0;
      end else begin
         if (req_valid && !req_stall) begin
            advance_decimator(req_data);
            requests_taken++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_reqs.size() != 0 &&
                (requests_taken < FIRST_LEN - 64 ||
                 (requests_taken >= FIRST_LEN + 600 &&
                  requests_taken < FIRST_LEN + 1200) ||
                 $urandom_range(99) >= 30)) begin
               req_valid <= 1'b1;
               req_data <= pending_reqs.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_verdicts.size() == 0) begin
               mismatches++;
               $display("%0t expected no verdict, actual slot=%0d give=%0d warm=%0d",
                        $time, rsp_data.out_slot, rsp_data.give_frame, rsp_data.warming_up);
            end else begin
               want = expected_verdicts.pop_front();
               if (rsp_data.out_slot !== want.out_slot ||
                   rsp_data.give_frame !== want.give_frame ||
                   rsp_data.warming_up !== want.warming_up) begin
                  mismatches++;
                  $display("%0t slot/give/warm expected %0d/%0d/%0d, actual %0d/%0d/%0d",
                           $time, want.out_slot, want.give_frame, want.warming_up,
                           rsp_data.out_slot, rsp_data.give_frame, rsp_data.warming_up);
               end
            end
            verdicts_seen++;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (!hold_done && verdicts_seen == HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_LEN;
            rsp_stall <= 1'b1;
         end else if (verdicts_seen >= 34 && verdicts_seen < 46) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(99) < 30);
         end
      end
   end

   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin : finish_run
      @(negedge reset);
      do @(posedge clock);
      while (pending_reqs.size() != 0 || req_valid || expected_verdicts.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/tfd_pkg.sv
rtl/telecine_frame_decimator_top.sv
dv/tb.sv
